### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro takes a label, a clock, a reset that disables the check,
// a condition, and the property that must follow from it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// The property must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/pol_pkg.sv
`default_nettype none

package pol_pkg;

  // Request operation codes.
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_POS   = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;
  localparam logic [2:0] OP_DEL_POS   = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [7:0]         position;
  } pol_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] first_value;
    logic signed [31:0] last_value;
  } pol_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted request
    logic commit;  // apply the captured request and update the result
  } pol_cmd_t;

endpackage

`default_nettype wire

### rtl/core/pol_shift_array.sv
`default_nettype none

module pol_shift_array #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     ins,
  input  wire logic                     del,
  input  wire logic [$clog2(DEPTH)-1:0] idx,
  input  wire logic [WIDTH-1:0]         din,
  output      logic [WIDTH-1:0]         head
);

  localparam int IW = $clog2(DEPTH);

  logic [WIDTH-1:0] cells [DEPTH];
  logic [WIDTH-1:0] below [DEPTH];
  logic [WIDTH-1:0] above [DEPTH];

  // Each cell sees its two neighbors; on an insert the cell at idx takes din.
  for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
    if (g == 0) begin : g_bot
      assign below[g] = din;
    end else begin : g_mid_bot
      assign below[g] = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign above[g] = cells[g];
    end else begin : g_mid_top
      assign above[g] = cells[g+1];
    end
  end

  // Insert opens a slot at idx by moving the upper cells up one place;
  // delete closes the slot at idx by moving the upper cells down.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ins) begin
        if (IW'(i) == idx) begin
          cells[i] <= din;
        end else if (IW'(i) > idx) begin
          cells[i] <= below[i];
        end
      end else if (del) begin
        if (IW'(i) >= idx) begin
          cells[i] <= above[i];
        end
      end
    end
  end

  assign head = cells[0];

endmodule

`default_nettype wire

### rtl/core/pol_ctrl.sv
`default_nettype none

module pol_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output      logic              req_stall,
  output      logic              rsp_valid,
  input  wire logic              rsp_stall,
  output      pol_pkg::pol_cmd_t cmd
);

  import pol_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   commit;

  // A captured request is applied once the result register is free.
  assign commit     = (state == S_EXEC) && (!rsp_valid || !rsp_stall);
  assign req_stall  = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && req_valid;
  assign cmd.commit = commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/pol_datapath.sv
`default_nettype none

module pol_datapath #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pol_pkg::pol_cmd_t cmd,
  input  wire pol_pkg::pol_in_t  req,
  output      pol_pkg::pol_out_t rsp
);

  import pol_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  pol_in_t         request;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [1:0]      status;
  logic [1:0]      status_next;
  logic            ins;
  logic            del;
  logic [IW-1:0]   idx_fwd;
  logic [IW-1:0]   idx_rev;
  logic [PW-1:0]   n_w;
  logic [PW-1:0]   pos_w;
  logic            full;
  logic            empty;
  logic [63:0]     value_ext;
  logic [DATA_WIDTH-1:0] din;
  logic [DATA_WIDTH-1:0] head_fwd;
  logic [DATA_WIDTH-1:0] head_rev;

  assign n_w       = PW'(count);
  assign pos_w     = PW'(request.position);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign value_ext = {32'b0, request.value};
  assign din       = value_ext[DATA_WIDTH-1:0];

  // The forward array holds the list front first; the reverse array holds
  // it back first. A slot at forward index k sits at reverse index n-1-k.
  always_comb begin
    status_next = ST_DONE;
    ins         = 1'b0;
    del         = 1'b0;
    idx_fwd     = '0;
    idx_rev     = '0;
    count_next  = count;
    case (request.operation)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (request.operation == OP_INS_FRONT) begin
          ins     = 1'b1;
          idx_fwd = '0;
          idx_rev = IW'(n_w);
        end else if (request.operation == OP_INS_BACK) begin
          ins     = 1'b1;
          idx_fwd = IW'(n_w);
          idx_rev = '0;
        end else if (pos_w == '0 || pos_w > n_w + PW'(1)) begin
          status_next = ST_INVALID;
        end else begin
          ins     = 1'b1;
          idx_fwd = IW'(pos_w - PW'(1));
          idx_rev = IW'(n_w + PW'(1) - pos_w);
        end
        if (ins) begin
          count_next = CW'(n_w + PW'(1));
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (request.operation == OP_DEL_FRONT) begin
          del     = 1'b1;
          idx_fwd = '0;
          idx_rev = IW'(n_w - PW'(1));
        end else if (request.operation == OP_DEL_BACK) begin
          del     = 1'b1;
          idx_fwd = IW'(n_w - PW'(1));
          idx_rev = '0;
        end else if (pos_w == '0 || pos_w > n_w) begin
          status_next = ST_INVALID;
        end else begin
          del     = 1'b1;
          idx_fwd = IW'(pos_w - PW'(1));
          idx_rev = IW'(n_w - pos_w);
        end
        if (del) begin
          count_next = CW'(n_w - PW'(1));
        end
      end
      default: begin
        status_next = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      request <= req;
    end
    if (cmd.commit) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  pol_shift_array #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_fwd (
    .clk  (clk),
    .ins  (cmd.commit && ins),
    .del  (cmd.commit && del),
    .idx  (idx_fwd),
    .din  (din),
    .head (head_fwd)
  );

  pol_shift_array #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_rev (
    .clk  (clk),
    .ins  (cmd.commit && ins),
    .del  (cmd.commit && del),
    .idx  (idx_rev),
    .din  (din),
    .head (head_rev)
  );

  // Everything below comes from registers that change only on a commit, or on reset for the count.
  assign rsp.status      = status;
  assign rsp.count       = 5'(count);
  assign rsp.first_value = empty ? 32'sd0 : 32'(64'(signed'(head_fwd)));
  assign rsp.last_value  = empty ? 32'sd0 : 32'(64'(signed'(head_rev)));

endmodule

`default_nettype wire

### rtl/core/positional_ordered_list.sv
// A request accepted while the controller is idle is captured, then applied in the execute step;
// its result becomes valid when that step commits it, once the result register is free.
// The block takes no new request while one is in execution, so the controller's accept and execute steps alternate.
// Reset (rst, synchronous, active high) empties the list and clears the handshake state;
// element storage is not cleared and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module positional_ordered_list #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output      logic              req_stall,
  input  wire pol_pkg::pol_in_t  req,
  output      logic              rsp_valid,
  input  wire logic              rsp_stall,
  output      pol_pkg::pol_out_t rsp
);

  import pol_pkg::*;

  // The controller sequences each item: it captures the request, then
  // applies it once the result register can take the new result.
  pol_cmd_t cmd;

  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // The datapath keeps the list twice, once front first and once back
  // first, so that both ends are always read at fixed cells. Inserts and
  // deletes at any position move all affected cells together at the commit.
  pol_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  // The result shows no elements at all: zero count and both ends zero.
  logic rsp_blank;
  // The result shows the list at capacity.
  logic rsp_at_cap;

  assign rsp_blank  = (rsp.count == 5'd0) && (rsp.first_value == 32'sd0) &&
                      (rsp.last_value == 32'sd0);
  assign rsp_at_cap = (rsp.count == 5'(CAPACITY));

  // An empty report means the list holds nothing and both ends read zero.
  `ASSERT_SAME(a_empty_report, clk, rst, rsp_valid && rsp.status == ST_EMPTY, rsp_blank)

  // A full report means the list is at capacity.
  `ASSERT_SAME(a_full_report, clk, rst, rsp_valid && rsp.status == ST_FULL, rsp_at_cap)

  // Once an item is taken, the block is busy with it in the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)

  // A result appears only after a request has been taken.
  `ASSERT_NEXT(a_result_needs_item, clk, rst, !rsp_valid && !req_stall, !rsp_valid)

endmodule

`default_nettype wire
